@@ rtl/grc_pkg.sv @@
// Package for the grid ray caster: field widths, map geometry, cell codes, face codes.
// No dependencies.
`default_nettype none
package grc_pkg;
  localparam int TILE_PIXELS = 64;
  localparam int MAP_COLUMNS = 64;
  localparam int MAP_ROWS = 64;
  localparam int DIST_W = 24;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [1:0] CELL_OPEN = 2'd0;
  localparam logic [1:0] CELL_EDGE = 2'd3;
  localparam logic [1:0] FACE_HUP = 2'd0;
  localparam logic [1:0] FACE_HDN = 2'd1;
  localparam logic [1:0] FACE_VRT = 2'd2;
  localparam logic [1:0] FACE_VLF = 2'd3;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic REG_PX = 1'b0;
  localparam logic REG_PY = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [5:0] cell_col;
    logic [5:0] cell_row;
    logic [1:0] cell_code;
    logic signed [15:0] ray_cos;
    logic signed [15:0] ray_sin;
  } in_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] hit_dist;
    logic [1:0]        hit_face;
    logic              left_map;
  } out_word_t;
endpackage
`default_nettype wire

@@ rtl/grc_if.sv @@
// Valid/ready channel interface carrying one word of type T.
// The payload type comes from the parameter T; it does not import grc_pkg.
`default_nettype none
interface grc_if #(parameter type T = logic) (input wire logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/grid_ray_caster_top.sv @@
// Grid ray caster top level: tile map memory, shared divider, DDA walker.
// Depends on grc_pkg and grc_if.
//
// channel | dir | payload
// in      | in  | kind, cell_col, cell_row, cell_code, ray_cos, ray_sin
// out     | out | hit_dist, hit_face, left_map
// cfg     | in  | cfg_we, cfg_index, cfg_data (player_x, player_y)
//
// A ray runs 4 divisions on the shared restoring divider (one quotient bit
// per cycle), a first map read, then walk steps (move, map read, advance,
// settle), up to MAP_COLUMNS+MAP_ROWS+2 steps, a last compare and a load of
// the output register. Reset is synchronous; the map is not cleared. The
// output register holds one result; words are taken while it waits, but a
// finished ray holds in the done state until the register is free.
`default_nettype none
module grid_ray_caster_top (
  input  wire logic clk,
  input  wire logic rst,
  grc_if.sink       in_ch,
  grc_if.source     out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);
  import grc_pkg::*;

  localparam int CW = (MAP_COLUMNS > 1) ? $clog2(MAP_COLUMNS) : 1;
  localparam int RW = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int AW = CW + RW;
  localparam int TSH = $clog2(TILE_PIXELS);
  localparam int PW = $clog2(TILE_PIXELS + 1);
  localparam int NUM_W = 32;  // offset up to 64 times 2^23
  localparam int QW = NUM_W;  // one quotient bit per numerator bit
  localparam int DCW = $clog2(QW);
  localparam int SW = $clog2(MAP_COLUMNS + MAP_ROWS + 3);
  localparam int STEPS = MAP_COLUMNS + MAP_ROWS + 2;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_READ = 3'd2,
                         S_EVAL = 3'd3, S_FIX = 3'd4, S_ADV = 3'd5,
                         S_EVAL2 = 3'd6, S_DONE = 3'd7;

  logic [2:0] state;
  logic [11:0] player_x, player_y;
  logic [1:0] map_mem [MAP_COLUMNS*MAP_ROWS];
  logic [1:0] rd_code;
  logic [AW-1:0] rd_addr;

  // ray context
  logic signed [15:0] rc, rs;
  logic [15:0] cmag, smag;
  logic [PW-1:0] aoff, boff;
  logic [DIST_W-1:0] hor, ver, inc_h, inc_v;
  logic signed [9:0] col, row;
  logic [SW-1:0] nstep;
  logic left;
  out_word_t obuf;
  logic ovalid;
  logic load_out;

  // divider
  logic [1:0] dsel;
  logic [DCW-1:0] dcnt;
  logic [NUM_W-1:0] dnum;
  logic [15:0] drem;
  logic [QW-1:0] dquo;
  logic [15:0] dmag;
  logic [16:0] dtrial;
  logic [16:0] ddiff;
  logic dge;
  logic [QW-1:0] dquo_next;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      player_x <= '0;
      player_y <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_PX) player_x <= cfg_data;
      else player_y <= cfg_data;
    end
  end

  function automatic logic [NUM_W-1:0] div_num(input logic [1:0] sel,
      input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [NUM_W-1:0] v;
    case (sel)
      2'd0: v = NUM_W'(a) << 23;
      2'd1: v = NUM_W'(b) << 23;
      default: v = NUM_W'(TILE_PIXELS) << 23;
    endcase
    return v;
  endfunction

  // one restoring step per cycle, numerator shifted out from the top
  assign dmag = dsel[0] ? cmag : smag;
  assign dtrial = {drem, dnum[NUM_W-1]};
  assign ddiff = dtrial - {1'b0, dmag};
  assign dge = dtrial >= {1'b0, dmag};
  assign dquo_next = {dquo[QW-2:0], dge};

  function automatic logic [DIST_W-1:0] qsat(input logic [QW-1:0] q,
      input logic [15:0] m);
    if (m == 16'd0 || q > QW'(DIST_MAX)) return DIST_MAX;
    return q[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] sadd(input logic [DIST_W-1:0] x,
      input logic [DIST_W-1:0] y);
    logic [DIST_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  // walk decision
  logic sx_nz, sy_nz, eq, lt;
  logic signed [9:0] col_n, row_n;
  assign sx_nz = rc != 16'sd0;
  assign sy_nz = rs != 16'sd0;
  assign eq = hor == ver;
  assign lt = hor < ver;
  assign row_n = (eq || lt) ? row + ((rs > 0) ? -10'sd1 : (rs < 0) ? 10'sd1 : 10'sd0) : row;
  assign col_n = (eq || !lt) ? col + ((rc < 0) ? -10'sd1 : (rc > 0) ? 10'sd1 : 10'sd0) : col;

  logic col_out;
  assign col_out = col < 0 || col >= 10'(MAP_COLUMNS);
  assign rd_addr = AW'(row[RW-1:0]) * AW'(MAP_COLUMNS) + AW'(col[CW-1:0]);

  in_word_t iw;
  assign iw = in_ch.data;
  assign in_ch.ready = state == S_IDLE;

  // boundary offsets of a new ray; a zero offset counts as one pixel
  logic [PW-1:0] xlow, ylow, a_raw, b_raw, a_in, b_in;
  assign ylow = PW'(player_y[TSH-1:0]);
  assign xlow = PW'(player_x[TSH-1:0]);
  assign a_raw = (iw.ray_sin > 0) ? ylow :
                 (iw.ray_sin < 0) ? PW'(TILE_PIXELS) - ylow : '0;
  assign b_raw = (iw.ray_cos < 0) ? xlow :
                 (iw.ray_cos > 0) ? PW'(TILE_PIXELS) - xlow : '0;
  assign a_in = (a_raw == '0) ? PW'(1) : a_raw;
  assign b_in = (b_raw == '0) ? PW'(1) : b_raw;

  // map memory: one write port, one registered read
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && iw.kind == KIND_WRITE &&
        32'(iw.cell_col) < MAP_COLUMNS && 32'(iw.cell_row) < MAP_ROWS)
      map_mem[AW'(iw.cell_row[RW-1:0]) * AW'(MAP_COLUMNS) + AW'(iw.cell_col[CW-1:0])]
        <= iw.cell_code;
    rd_code <= map_mem[rd_addr];
  end

  logic [1:0] code_now;
  assign code_now = col_out ? CELL_EDGE : rd_code;

  // load the output register once it is empty or being sent
  assign load_out = state == S_DONE && (!ovalid || out_ch.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (load_out) ovalid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready && iw.kind != KIND_WRITE) begin
            rc <= iw.ray_cos;
            rs <= iw.ray_sin;
            cmag <= iw.ray_cos[15] ? 16'(-iw.ray_cos) : iw.ray_cos;
            smag <= iw.ray_sin[15] ? 16'(-iw.ray_sin) : iw.ray_sin;
            col <= 10'(player_x[11:TSH]);
            row <= 10'(player_y[11:TSH]);
            aoff <= a_in;
            boff <= b_in;
            dsel <= 2'd0;
            dcnt <= '0;
            drem <= '0;
            dquo <= '0;
            dnum <= div_num(2'd0, a_in, b_in);
            left <= 1'b0;
            nstep <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt == DCW'(QW-1)) begin
            case (dsel)
              2'd0: hor <= qsat(dquo_next, dmag);
              2'd1: ver <= qsat(dquo_next, dmag);
              2'd2: inc_h <= qsat(dquo_next, dmag);
              default: inc_v <= qsat(dquo_next, dmag);
            endcase
            dcnt <= '0;
            drem <= '0;
            dquo <= '0;
            dsel <= dsel + 2'd1;
            dnum <= div_num(dsel + 2'd1, aoff, boff);
            if (dsel == 2'd3) begin
              if (row >= 10'(MAP_ROWS)) begin
                left <= 1'b1;
                state <= S_DONE;
              end else if (sx_nz || sy_nz) state <= S_READ;
              else state <= S_DONE;
            end
          end else begin
            dcnt <= dcnt + DCW'(1);
            drem <= dge ? ddiff[15:0] : dtrial[15:0];
            dquo <= dquo_next;
            dnum <= {dnum[NUM_W-2:0], 1'b0};
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (code_now != CELL_OPEN || nstep == SW'(STEPS)) state <= S_DONE;
          else begin
            nstep <= nstep + SW'(1);
            if (row_n < 0 || row_n >= 10'(MAP_ROWS)) begin
              row <= row_n;
              col <= col_n;
              left <= 1'b1;
              state <= S_DONE;
            end else begin
              row <= row_n;
              col <= col_n;
              state <= S_FIX;
            end
          end
        end
        S_FIX: state <= S_ADV;
        S_ADV: begin
          // new cell read; advance distances only through open cells
          if (code_now == CELL_OPEN) begin
            if (eq || lt) hor <= sadd(hor, inc_h);
            if (eq || !lt) ver <= sadd(ver, inc_v);
          end
          state <= S_EVAL2;
        end
        S_EVAL2: state <= S_EVAL;
        S_DONE: begin
          if (load_out) begin
            obuf.hit_dist <= lt ? hor : ver;
            obuf.hit_face <= lt ? ((rs > 0) ? FACE_HUP : FACE_HDN)
                                : ((rc > 0) ? FACE_VRT : FACE_VLF);
            obuf.left_map <= left;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data = obuf;

`ifndef SYNTH
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !out_ch.ready |=> ovalid && $stable(obuf)) else $error("result lost");
  a_done_sets: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> ovalid) else $error("no result after walk");
`endif
endmodule
`default_nettype wire
